/* hw/rtl/s2x_pkg.sv */
package s2x_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ADDR_W  = COL_W + 1;
    localparam int DEPTH   = 2 * MAX_WIDTH;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Control and payload carried from the read issue to the neighbor compare.
    typedef struct packed {
        logic               emit;
        logic               first;
        logic               last;
        logic               a_from_mem;
        logic               d_is_p;
        logic [PIX_W-1:0]   d;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               frame_last;
    } stage_t;

    typedef struct packed {
        logic [PIX_W-1:0]   top_left;
        logic [PIX_W-1:0]   top_right;
        logic [PIX_W-1:0]   bottom_left;
        logic [PIX_W-1:0]   bottom_right;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic               frame_last;
    } block_t;

endpackage

/* hw/rtl/scale2x_pixel_upscaler.sv */
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | func, pixel
// output  | out       | out_valid / out_ready| top_left, top_right, bottom_left,
//         |           |                      | bottom_right, src_col, src_row, frame_last
// config  | in        | cfg_we               | cfg_index, cfg_data
//
// A word is accepted per cycle while in_ready is high; its block passes s1 before out_valid.
// Line store: one write and two read ports. Pixel words write their pixel; every word reads
// the right neighbor and the pixel two rows up, while a two-entry window holds the center
// and left pixels and a register keeps the first pixel of the row for the next row's start.
// Reset clears counters and flags and sets both sizes to 16; line store data is left unset.
// A stall on out_ready backs up through the compare stage to in_ready in the same cycle.
module scale2x_pixel_upscaler
    import s2x_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [PIX_W-1:0]   pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   top_left,
    output logic [PIX_W-1:0]   top_right,
    output logic [PIX_W-1:0]   bottom_left,
    output logic [PIX_W-1:0]   bottom_right,
    output logic [COORD_W-1:0] src_col,
    output logic [COORD_W-1:0] src_row,
    output logic               frame_last,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [COORD_W-1:0] in_col_reg, in_col_next;
    logic [COORD_W-1:0] in_row_reg, in_row_next;
    logic [COORD_W-1:0] drain_col_reg, drain_col_next;
    logic               draining_reg, draining_next;

    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;
    logic [PIX_W-1:0]   rd_c_reg, rd_a_reg;
    logic [PIX_W-1:0]   p_pend_reg, b_prev_reg;
    logic [PIX_W-1:0]   first_pix_reg;

    logic               out_valid_reg, out_valid_next;
    block_t             block_reg, block_next;

    logic [PIX_W-1:0]   line_mem [DEPTH];

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [DIM_W-1:0]   w_last;
    logic               accept, is_pix, is_drain, load_s1, s1_adv;
    logic [COORD_W-1:0] col0, row_blk;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic               last0;
    logic [ADDR_W-1:0]  rd_c_addr, rd_a_addr, wr_addr;
    logic               wr_en;
    logic [PIX_W-1:0]   p, b, c, a, d;

    // Sizes are used saturated to 1..maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(16);
            height_reg <= DIM_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign accept   = in_valid && in_ready;
    assign is_pix   = (func == FUNC_PIXEL) && !draining_reg;
    assign is_drain = (func == FUNC_DRAIN) && draining_reg;
    assign load_s1  = accept && (is_pix || is_drain);

    assign col0    = is_drain ? drain_col_reg : in_col_reg;
    assign col_inc = {1'b0, col0} + DIM_W'(1);
    assign row_inc = {1'b0, in_row_reg} + DIM_W'(1);
    assign last0   = col_inc >= w_eff;
    assign row_blk = is_drain ? in_row_reg : in_row_reg - COORD_W'(1);
    assign w_last  = w_eff - DIM_W'(1);

    // At the last column the right neighbor is clamped to the final column. After a
    // mid-row width shrink the center can lie past it, so the port still reads it.
    always_comb
    begin
        if (last0)
            rd_c_addr = {row_blk[0], w_last[COL_W-1:0]};
        else
            rd_c_addr = {row_blk[0], col_inc[COL_W-1:0]};
    end

    assign rd_a_addr = {~row_blk[0], col0[COL_W-1:0]};
    assign wr_en     = accept && is_pix;
    assign wr_addr   = {in_row_reg[0], in_col_reg[COL_W-1:0]};

    // The upper-row read hits the entry being written and must see the old contents;
    // the right-neighbor read always lies in the other half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= pixel;
        if (load_s1)
        begin
            rd_c_reg <= line_mem[rd_c_addr];
            rd_a_reg <= line_mem[rd_a_addr];
        end
    end

    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        drain_col_next = drain_col_reg;
        draining_next  = draining_reg;
        if (accept && is_pix)
        begin
            if (last0)
            begin
                in_col_next = '0;
                if (row_inc >= h_eff)
                begin
                    draining_next  = 1'b1;
                    drain_col_next = '0;
                end
                else
                begin
                    in_row_next = row_inc[COORD_W-1:0];
                end
            end
            else
            begin
                in_col_next = col_inc[COORD_W-1:0];
            end
        end
        else if (accept && is_drain)
        begin
            if (last0)
            begin
                draining_next  = 1'b0;
                drain_col_next = '0;
                in_col_next    = '0;
                in_row_next    = '0;
            end
            else
            begin
                drain_col_next = col_inc[COORD_W-1:0];
            end
        end
    end

    always_comb
    begin
        s1_next.emit       = is_drain || (in_row_reg != '0);
        s1_next.first      = col0 == '0;
        s1_next.last       = last0;
        s1_next.a_from_mem = row_blk != '0;
        s1_next.d_is_p     = is_drain;
        s1_next.d          = pixel;
        s1_next.col        = col0;
        s1_next.row        = row_blk;
        s1_next.frame_last = is_drain && last0;
    end

    assign s1_adv   = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        priority if (load_s1)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Neighbor compare: P and B come from the window, C and A from the reads (A is P on row 0).
    assign p = p_pend_reg;
    assign c = rd_c_reg;
    assign b = s1_reg.first ? p : b_prev_reg;
    assign a = s1_reg.a_from_mem ? rd_a_reg : p;
    assign d = s1_reg.d_is_p ? p : s1_reg.d;

    always_comb
    begin
        block_next.top_left     = (b == a && a != c && b != d) ? b : p;
        block_next.top_right    = (a == c && a != b && c != d) ? c : p;
        block_next.bottom_left  = (b == d && b != a && d != c) ? b : p;
        block_next.bottom_right = (d == c && d != b && c != a) ? c : p;
        block_next.src_col      = s1_reg.col;
        block_next.src_row      = s1_reg.row;
        block_next.frame_last   = s1_reg.frame_last;
    end

    always_comb
    begin
        priority if (s1_adv && s1_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            drain_col_reg <= '0;
            draining_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            drain_col_reg <= drain_col_next;
            draining_reg  <= draining_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // After the last column the center of the next word is the first pixel of the row
    // just completed.
    always_ff @(posedge clk)
    begin
        if (load_s1)
            s1_reg <= s1_next;
        if (wr_en && in_col_reg == '0)
            first_pix_reg <= pixel;
        if (s1_adv)
        begin
            b_prev_reg <= p;
            p_pend_reg <= s1_reg.last ? first_pix_reg : rd_c_reg;
        end
        if (s1_adv && s1_reg.emit)
            block_reg <= block_next;
    end

    assign out_valid    = out_valid_reg;
    assign top_left     = block_reg.top_left;
    assign top_right    = block_reg.top_right;
    assign bottom_left  = block_reg.bottom_left;
    assign bottom_right = block_reg.bottom_right;
    assign src_col      = block_reg.src_col;
    assign src_row      = block_reg.src_row;
    assign frame_last   = block_reg.frame_last;

endmodule
